/* rtl/core/fns_pkg.sv */
// Shared types and constants for the four-neighbor sum stencil.
// Used by the delay-line cell, the result queue cell and the top level.
// No dependencies.
package fns_pkg;

	// Matrix geometry and sample format
	localparam int MATRIX_SIZE = 4;
	localparam int SAMPLE_W    = 16;
	localparam int SUM_W       = SAMPLE_W + 2;
	localparam int HIST_DEPTH  = 2 * MATRIX_SIZE;
	localparam int IDX_W       = (MATRIX_SIZE > 2) ? $clog2(MATRIX_SIZE) : 1;

	// Result queue sizing: one sample causes at most three results
	localparam int MAX_PUSH    = 3;
	localparam int PUSH_SEL_W  = $clog2(MAX_PUSH);
	localparam int QUEUE_DEPTH = MATRIX_SIZE + 2;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// One result as it sits in the queue
	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic                    run_last;
		logic                    frame_done;
	} fns_res_t;

	// Per-cell queue control
	typedef struct packed {
		logic                  take_next;
		logic                  load;
		logic [PUSH_SEL_W-1:0] sel;
		logic                  valid_next;
	} fns_qctl_t;

endpackage

/* rtl/core/fns_tap_cell.sv */
// One stage of the sample delay line: holds one sample, passes it on per transfer.
// Depends on fns_pkg.
module fns_tap_cell
	import fns_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       shift_en,
	input  logic signed [SAMPLE_W-1:0] d,
	output logic signed [SAMPLE_W-1:0] q
);

	logic signed [SAMPLE_W-1:0] sample_q;

	// shift on every accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q <= '0;
		end else if (shift_en) begin
			sample_q <= d;
		end
	end

	assign q = sample_q;

endmodule

/* rtl/core/fns_queue_cell.sv */
// One slot of the result queue: holds, takes from its upper neighbor, or loads a new result.
// Depends on fns_pkg.
module fns_queue_cell
	import fns_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  fns_qctl_t                 ctl,
	input  fns_res_t                  next_entry,
	input  fns_res_t [MAX_PUSH-1:0]   new_entries,
	output fns_res_t                  entry,
	output logic                      valid
);

	fns_res_t entry_q;
	fns_res_t load_entry;
	logic     valid_q;

	// pick which freshly computed result lands here
	always_comb begin
		unique case (ctl.sel)
			PUSH_SEL_W'(0): load_entry = new_entries[0];
			PUSH_SEL_W'(1): load_entry = new_entries[1];
			default:        load_entry = new_entries[MAX_PUSH-1];
		endcase
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= load_entry;
		end else if (ctl.take_next) begin
			entry_q <= next_entry;
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ctl.valid_next;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule

/* rtl/core/four_neighbour_sum_stencil.sv */
// Four-neighbor sum over a streamed square matrix, zero padded at the edges.
// A result is offered in the cycle after the transfer that causes it (empty queue).
// Throughput: one sample per cycle; sample_ready drops only while the result queue lacks
// room for the results the next sample would cause, which a stalled output side causes.
// Reset clears the row/column counters, the delay line and the result queue.
// Depends on fns_pkg, fns_tap_cell, fns_queue_cell.
module four_neighbour_sum_stencil
	import fns_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       sample_valid,
	output logic                       sample_ready,
	input  logic signed [SAMPLE_W-1:0] sample_value,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic signed [SUM_W-1:0]    neighbour_sum,
	output logic [IDX_W-1:0]           row_index,
	output logic [IDX_W-1:0]           col_index,
	output logic                       run_last,
	output logic                       frame_done
);

	function automatic logic signed [SUM_W-1:0] ext(input logic signed [SAMPLE_W-1:0] x);
		ext = {{(SUM_W-SAMPLE_W){x[SAMPLE_W-1]}}, x};
	endfunction

	logic                       accept;
	logic                       pop;
	logic [IDX_W-1:0]           row_q;
	logic [IDX_W-1:0]           col_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [CNT_W-1:0]           base;
	logic [CNT_W-1:0]           push_cnt;
	logic [CNT_W-1:0]           npush;
	logic [CNT_W-1:0]           fill;
	logic [CNT_W:0]             need;
	logic                       row_last;
	logic                       col_last;
	logic                       a_vld;
	logic                       b_vld;
	logic                       c_vld;
	logic signed [SUM_W-1:0]    v_ext;
	logic signed [SUM_W-1:0]    sum_a;
	logic signed [SUM_W-1:0]    sum_b;
	logic signed [SUM_W-1:0]    sum_c;
	logic signed [SAMPLE_W-1:0] tap [HIST_DEPTH];
	fns_res_t [MAX_PUSH-1:0]    new_entries;
	fns_res_t                   q_entry [QUEUE_DEPTH+1];
	logic                       q_valid [QUEUE_DEPTH];
	fns_qctl_t                  q_ctl   [QUEUE_DEPTH];

	// accept when the queue can take every result this position releases
	assign accept       = sample_valid & sample_ready;
	assign pop          = q_valid[0] & result_ready;
	assign need         = {1'b0, cnt_q} + {1'b0, push_cnt};
	assign sample_ready = (need <= (CNT_W+1)'(QUEUE_DEPTH));

	// delay line: a chain of sample cells, newest at tap[0]
	for (genvar j = 0; j < HIST_DEPTH; j++) begin : g_tap
		if (j == 0) begin : g_head
			fns_tap_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (accept),
				.d        (sample_value),
				.q        (tap[j])
			);
		end else begin : g_body
			fns_tap_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.shift_en (accept),
				.d        (tap[j-1]),
				.q        (tap[j])
			);
		end
	end

	// position counters
	assign row_last = (row_q == IDX_W'(MATRIX_SIZE - 1));
	assign col_last = (col_q == IDX_W'(MATRIX_SIZE - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + IDX_W'(1);
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end

	// neighbor sums for the up to three finished positions
	assign v_ext = ext(sample_value);
	assign a_vld = (row_q != '0);
	assign b_vld = row_last && (col_q != '0);
	assign c_vld = row_last && col_last;

	always_comb begin
		// position above the incoming sample
		sum_a = v_ext
			+ ((row_q > IDX_W'(1))      ? ext(tap[HIST_DEPTH-1])  : '0)
			+ ((col_q != '0)            ? ext(tap[MATRIX_SIZE])   : '0)
			+ (!col_last                ? ext(tap[MATRIX_SIZE-2]) : '0);
		// last-row position left of the incoming sample
		sum_b = ext(tap[MATRIX_SIZE]) + v_ext
			+ ((col_q > IDX_W'(1)) ? ext(tap[1]) : '0);
		// bottom-right corner
		sum_c = ext(tap[MATRIX_SIZE-1]) + ext(tap[0]);

		new_entries[0].sum        = sum_a;
		new_entries[0].row        = row_q - IDX_W'(1);
		new_entries[0].col        = col_q;
		new_entries[0].run_last   = !b_vld;
		new_entries[0].frame_done = 1'b0;

		new_entries[1].sum        = sum_b;
		new_entries[1].row        = row_q;
		new_entries[1].col        = col_q - IDX_W'(1);
		new_entries[1].run_last   = !c_vld;
		new_entries[1].frame_done = 1'b0;

		new_entries[2].sum        = sum_c;
		new_entries[2].row        = row_q;
		new_entries[2].col        = col_q;
		new_entries[2].run_last   = 1'b1;
		new_entries[2].frame_done = 1'b1;
	end

	// queue fill bookkeeping
	assign push_cnt = CNT_W'(a_vld) + CNT_W'(b_vld) + CNT_W'(c_vld);
	assign npush    = accept ? push_cnt : '0;
	assign base     = cnt_q - CNT_W'(pop);
	assign fill     = base + npush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= fill;
		end
	end

	// result queue: a chain of cells draining toward cell 0
	assign q_entry[QUEUE_DEPTH] = '0;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_queue
		always_comb begin
			q_ctl[i].take_next  = pop && (CNT_W'(i) < base);
			q_ctl[i].load       = (CNT_W'(i) >= base) && (CNT_W'(i) < fill);
			q_ctl[i].sel        = PUSH_SEL_W'(CNT_W'(i) - base);
			q_ctl[i].valid_next = (CNT_W'(i) < fill);
		end

		fns_queue_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (q_ctl[i]),
			.next_entry  (q_entry[i+1]),
			.new_entries (new_entries),
			.entry       (q_entry[i]),
			.valid       (q_valid[i])
		);
	end

	// head of the queue drives the output port
	assign result_valid  = q_valid[0];
	assign neighbour_sum = q_entry[0].sum;
	assign row_index     = q_entry[0].row;
	assign col_index     = q_entry[0].col;
	assign run_last      = q_entry[0].run_last;
	assign frame_done    = q_entry[0].frame_done;

`ifndef SYNTH
	// occupancy count never runs past the queue
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("result queue count out of range");

	// head valid agrees with the occupancy count
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid == (cnt_q != '0))
		else $error("queue head valid disagrees with count");

	// final sample of a frame wraps the counters
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && row_last && col_last |=> (row_q == '0) && (col_q == '0))
		else $error("position counters failed to wrap");

	// the corner result always closes its transfer's run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_done |-> run_last)
		else $error("frame_done without run_last");
`endif

endmodule
